// ----- sv/dcfp_pkg.sv -----
// dcfp_pkg: shared types, constants and helpers of the command frame parser
// no dependencies; imported by every module of the block
package dcfp_pkg;

   // widest store position, sized for the largest supported store depth
   localparam int MAX_POS_W = 6;

   // fixed frame layout: 0 start, 1 type, 2 cmd low, 3 cmd high, 4 length, 5.. payload
   localparam int POS_START   = 0;
   localparam int POS_MSG     = 1;
   localparam int POS_CMD_LO  = 2;
   localparam int POS_CMD_HI  = 3;
   localparam int POS_LEN     = 4;
   localparam int HDR_LEN     = 5;

   // front to back queue depth
   localparam int QUEUE_DEPTH = 4;

   // recognized command codes
   localparam logic [15:0] CMD_CODE_A = 16'h0001;
   localparam logic [15:0] CMD_CODE_B = 16'h0002;
   localparam logic [15:0] CMD_CODE_C = 16'h0003;
   localparam logic [15:0] CMD_CODE_D = 16'h0010;

   // configuration register map
   localparam int   CSR_ADDR_W    = 3;
   localparam logic CSR_IDX_START = 1'b0;
   localparam logic CSR_IDX_STOP  = 1'b1;
   localparam logic [7:0] START_RESET = 8'h02;
   localparam logic [7:0] STOP_RESET  = 8'h03;

   // result word layout
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = 7;

   // one store operation handed from the front to the back
   typedef struct packed {
      logic                 close;
      logic [MAX_POS_W-1:0] pos;
      logic [7:0]           data;
   } dcfp_op_type;

   // back end sequencer
   typedef enum logic [4:0] {
      BK_IDLE = 5'b00001,
      BK_LEN  = 5'b00010,
      BK_CRC  = 5'b00100,
      BK_RD   = 5'b01000,
      BK_OUT  = 5'b10000
   } dcfp_back_state_type;

   function automatic logic cmd_known(input logic [15:0] cmd);
      return (cmd == CMD_CODE_A) || (cmd == CMD_CODE_B) ||
             (cmd == CMD_CODE_C) || (cmd == CMD_CODE_D);
   endfunction

endpackage

// ----- sv/dcfp_front.sv -----
// dcfp_front: accepts received bytes, tracks frame open state and fill position
// and turns each byte into a store write or a frame close; uses dcfp_pkg
module dcfp_front #(
   parameter int BUF_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           start_delim,
   input  logic [7:0]           stop_delim,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // rx_byte
   input  logic                 q_full,
   output logic                 push_valid,
   output dcfp_pkg::dcfp_op_type push_op
);
   import dcfp_pkg::*;

   localparam int PW = $clog2(BUF_DEPTH);
   localparam logic [PW-1:0] FILL_MAX = PW'(BUF_DEPTH - 1);

   logic          in_frame_ff, in_frame_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic          accept, is_start, is_stop;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign is_start   = (req_tdata == start_delim);
   assign is_stop    = !is_start && (req_tdata == stop_delim);

   // classify the item against the frame state
   always_comb begin
      in_frame_in  = in_frame_ff;
      fill_in      = fill_ff;
      push_valid   = 1'b0;
      push_op.close = 1'b0;
      push_op.pos   = MAX_POS_W'(fill_ff);
      push_op.data  = req_tdata;
      if (accept) begin
         if (is_start && !in_frame_ff) begin
            // open a frame at position zero
            push_valid  = 1'b1;
            push_op.pos = MAX_POS_W'(POS_START);
            in_frame_in = 1'b1;
            fill_in     = PW'(1);
         end else if (is_stop) begin
            if (in_frame_ff) begin
               push_valid    = 1'b1;
               push_op.close = 1'b1;
               in_frame_in   = 1'b0;
               fill_in       = '0;
            end
         end else if (in_frame_ff) begin
            // append, or drop the frame when the store is full
            if (fill_ff < FILL_MAX) begin
               push_valid = 1'b1;
               fill_in    = fill_ff + PW'(1);
            end else begin
               in_frame_in = 1'b0;
               fill_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         fill_ff     <= fill_in;
      end
   end

endmodule

// ----- sv/dcfp_queue.sv -----
// dcfp_queue: short first-in first-out queue of store operations
// between front and back; uses dcfp_pkg
module dcfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  dcfp_pkg::dcfp_op_type push_op,
   output logic                  full,
   input  logic                  pop,
   output dcfp_pkg::dcfp_op_type pop_op,
   output logic                  empty
);
   import dcfp_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dcfp_op_type   entry_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign pop_op  = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         if (do_push && !do_pop)      count_ff <= count_ff + CW'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CW'(1);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_op;
   end

endmodule

// ----- sv/dcfp_back.sv -----
// dcfp_back: executes store writes, decodes a closed frame and walks
// the payload out one result item at a time; uses dcfp_pkg
module dcfp_back #(
   parameter int BUF_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  dcfp_pkg::dcfp_op_type   q_op,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [dcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                    rsp_tlast
);
   import dcfp_pkg::*;

   localparam int PW = $clog2(BUF_DEPTH);
   localparam logic [PW-1:0] ROOM   = PW'(BUF_DEPTH - 6);
   localparam logic [7:0]    ROOM_B = 8'(BUF_DEPTH - 6);
   localparam logic [PW-1:0] PAY0   = PW'(HDR_LEN);

   dcfp_back_state_type state_ff, state_in;

   logic [7:0]    mem [BUF_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [PW-1:0] rd_addr;
   logic          rd_ok_ff;

   logic [7:0]    msg_ff, cmd_lo_ff, cmd_hi_ff, decl_ff;
   logic [PW-1:0] close_pos_ff, len_ff, k_ff, last_k_ff;
   logic          clamped_ff;
   logic [7:0]    crc_ff;

   logic          rsp_valid_ff, rsp_last_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [PW-1:0] op_pos, len_c;
   logic          wr_en, rsp_take;
   logic [15:0]   cmd;
   logic [7:0]    pay_byte;
   logic          pay_valid;

   assign op_pos   = PW'(q_op.pos);
   assign q_pop    = state_ff[0] && !q_empty;
   assign wr_en    = q_pop;
   assign rsp_take = rsp_valid_ff && rsp_tready;
   assign len_c    = (decl_ff > ROOM_B) ? ROOM : PW'(decl_ff);
   assign cmd      = {cmd_hi_ff, cmd_lo_ff};
   assign pay_valid = (len_ff != '0);
   assign pay_byte  = (pay_valid && rd_ok_ff) ? rd_data_ff : 8'h00;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer and store read address
   always_comb begin
      state_in = state_ff;
      rd_addr  = PAY0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_op.close) state_in = BK_LEN;
         end
         BK_LEN: begin
            rd_addr  = PAY0 + len_c;
            state_in = BK_CRC;
         end
         BK_CRC: begin
            rd_addr  = PAY0;
            state_in = BK_RD;
         end
         BK_RD: begin
            state_in = BK_OUT;
         end
         BK_OUT: begin
            rd_addr = PAY0 + k_ff + PW'(1);
            if (rsp_take) state_in = rsp_last_ff ? BK_IDLE : BK_RD;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // frame store with registered read; positions past the close read as zero
   always_ff @(posedge clock) begin
      if (wr_en) mem[op_pos] <= q_op.data;
      rd_data_ff <= mem[rd_addr];
      rd_ok_ff   <= (rd_addr <= close_pos_ff);
   end

   // header capture, cleared when a frame opens
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (int'(op_pos))
            POS_START: begin
               msg_ff    <= 8'h00;
               cmd_lo_ff <= 8'h00;
               cmd_hi_ff <= 8'h00;
               decl_ff   <= 8'h00;
            end
            POS_MSG:    msg_ff    <= q_op.data;
            POS_CMD_LO: cmd_lo_ff <= q_op.data;
            POS_CMD_HI: cmd_hi_ff <= q_op.data;
            POS_LEN:    decl_ff   <= q_op.data;
            default: ;
         endcase
         if (q_op.close) close_pos_ff <= op_pos;
      end
   end

   // frame decode and payload walk
   always_ff @(posedge clock) begin
      if (state_ff == BK_LEN) begin
         len_ff     <= len_c;
         clamped_ff <= (decl_ff > ROOM_B);
         last_k_ff  <= (len_c == '0) ? '0 : len_c - PW'(1);
      end
      if (state_ff == BK_CRC) begin
         crc_ff <= rd_ok_ff ? rd_data_ff : 8'h00;
         k_ff   <= '0;
      end
      if (state_ff == BK_OUT && rsp_take) k_ff <= k_ff + PW'(1);
      if (state_ff == BK_RD) begin
         rsp_data_ff <= {RSP_PAD_W'(0), crc_ff, pay_byte,
                         pay_valid ? 6'(k_ff) : 6'd0, pay_valid, clamped_ff,
                         decl_ff, cmd_known(cmd), cmd, msg_ff};
         rsp_last_ff <= (k_ff == last_k_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_RD) rsp_valid_ff <= 1'b1;
         else if (rsp_take)     rsp_valid_ff <= 1'b0;
      end
   end

endmodule

// ----- sv/delimited_command_frame_parser.sv -----
// Start/stop delimited command frame parser. Received bytes enter on the req_ stream
// and are sorted by a front end that tracks the open frame and fill position; store
// operations pass through a four-entry queue to a back end that owns the frame store
// (one write port and one registered read port) and emits one rsp_ item per declared
// payload byte, clamped to BUF_DEPTH-6, or a single item for an empty payload, with
// tlast on the final one. The front takes one byte per cycle while the queue has room.
// The back writes stored bytes while idle, decodes each closed frame in a length state
// and a check-byte state, and then steps each result item through a store read state
// and an output state that holds until the item is taken. No clearing pass is needed
// after reset. Delimiters are set over the csr_ port: start at 0x0, stop at 0x4.
module delimited_command_frame_parser #(
   parameter int BUF_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [dcfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // decoded results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] msg_type, [23:8] command_code, [24] command_known,
   // [32:25] declared_length, [33] length_clamped, [34] payload_valid,
   // [40:35] payload_index, [48:41] payload_byte, [56:49] crc_byte, [63:57] zero
   output logic [dcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast
);
   import dcfp_pkg::*;

   logic [7:0]  start_ff, stop_ff;
   logic        csr_wr;
   logic        push_valid, q_full, q_empty, q_pop;
   dcfp_op_type push_op, pop_op;

   // delimiter registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_STOP) ? {24'h0, stop_ff} : {24'h0, start_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         stop_ff  <= STOP_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_START) start_ff <= csr_pwdata[7:0];
         else                               stop_ff  <= csr_pwdata[7:0];
      end
   end

   dcfp_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start_delim (start_ff),
      .stop_delim  (stop_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_op     (push_op)
   );

   dcfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (q_pop),
      .pop_op     (pop_op),
      .empty      (q_empty)
   );

   dcfp_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_op       (pop_op),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/dcfp_checker.sv -----
// dcfp_checker: port-level checks of the command frame parser results
// depends on dcfp_pkg; bound to delimited_command_frame_parser below
module dcfp_checker #(
   parameter int BUF_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [dcfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic        rsp_tlast
);
   import dcfp_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // clamp flag follows the declared length
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33] == (rsp_tdata[32:25] > 8'(BUF_DEPTH - 6)))
      else $error("length clamp flag wrong");

   // an empty payload gives one closing item
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[34] |-> rsp_tlast)
      else $error("empty payload item not last");

   // an empty payload carries zero index and byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[34] |-> rsp_tdata[48:35] == 14'd0)
      else $error("empty payload item has payload bits");

endmodule

bind delimited_command_frame_parser dcfp_checker #(.BUF_DEPTH(BUF_DEPTH)) u_dcfp_checker (.*);
